### rtl/core/hus_pkg.sv
// ----------------------------------------------------------------------------
// hus_pkg
// Shared types, character codes and helpers for the URL splitter.
// ----------------------------------------------------------------------------
package hus_pkg;

  typedef enum logic [3:0] {
    PH_SCHEME   = 4'd0,
    PH_SCHEME_S = 4'd1,
    PH_SLASH1   = 4'd2,
    PH_SLASH2   = 4'd3,
    PH_HOST     = 4'd4,
    PH_V6       = 4'd5,
    PH_AFTER_V6 = 4'd6,
    PH_PORT     = 4'd7,
    PH_PATH     = 4'd8,
    PH_QUERY    = 4'd9,
    PH_IGNORED  = 4'd10
  } phase_t;

  typedef enum logic [2:0] {
    CL_SCHEME  = 3'd0,
    CL_DELIM   = 3'd1,
    CL_HOST    = 3'd2,
    CL_PORT    = 3'd3,
    CL_PATH    = 3'd4,
    CL_QUERY   = 3'd5,
    CL_IGNORED = 3'd6,
    CL_ERROR   = 3'd7
  } byte_class_t;

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_S = 8'h73;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  localparam logic [2:0]  HTTP_LETTERS = 3'd4;
  localparam logic [16:0] PORT_SAT   = 17'd65536;
  localparam logic [16:0] PORT_MAX   = 17'd65535;
  localparam logic [15:0] PORT_HTTP  = 16'd80;
  localparam logic [15:0] PORT_HTTPS = 16'd443;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  scheme_index;
    logic        secure_flag;
    logic [16:0] port_accum;
    logic        port_digit_seen;
    logic        host_nonempty;
    logic        path_seen;
    logic        query_seen;
    logic        failed;
  } parse_state_t;

  typedef struct packed {
    logic        ok;
    logic        is_secure;
    logic [15:0] port_number;
    logic        path_given;
    logic        query_given;
  } url_report_t;

  localparam parse_state_t STATE_RESET = '{
    phase:           PH_SCHEME,
    scheme_index:    3'd0,
    secure_flag:     1'b0,
    port_accum:      17'd0,
    port_digit_seen: 1'b0,
    host_nonempty:   1'b0,
    path_seen:       1'b0,
    query_seen:      1'b0,
    failed:          1'b0
  };

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c + CASE_GAP;
    end
    return c;
  endfunction

  // letters of "http"
  function automatic logic [7:0] scheme_char(input logic [1:0] idx);
    case (idx)
      2'd0:    return 8'h68;
      2'd1:    return 8'h74;
      2'd2:    return 8'h74;
      default: return 8'h70;
    endcase
  endfunction

  function automatic logic port_in_range(input parse_state_t s);
    return s.port_digit_seen && (s.port_accum != 17'd0) && (s.port_accum <= PORT_MAX);
  endfunction

endpackage

### rtl/core/hus_step.sv
// ----------------------------------------------------------------------------
// hus_step
// Per-byte parser transition: labels the byte and works out the next state.
// ----------------------------------------------------------------------------
module hus_step (
  input  hus_pkg::parse_state_t cur,
  input  logic [7:0]            ch,
  output hus_pkg::parse_state_t nxt,
  output hus_pkg::byte_class_t  cls
);
  import hus_pkg::*;

  logic [7:0]  lc;
  logic [20:0] acc_x10;
  logic        bad;

  assign lc = to_lower(ch);
  // accum * 10 + digit, wide enough for the saturated value
  assign acc_x10 = ({4'd0, cur.port_accum} << 3) + ({4'd0, cur.port_accum} << 1)
                 + {17'd0, ch[3:0]};

  always_comb begin
    nxt = cur;
    cls = CL_ERROR;
    bad = 1'b0;
    if (!cur.failed) begin
      case (cur.phase)
        PH_SCHEME: begin
          if (cur.scheme_index < HTTP_LETTERS && lc == scheme_char(cur.scheme_index[1:0])) begin
            nxt.scheme_index = cur.scheme_index + 3'd1;
            if (cur.scheme_index == HTTP_LETTERS - 3'd1) begin
              nxt.phase = PH_SCHEME_S;
            end
            cls = CL_SCHEME;
          end else begin
            bad = 1'b1;
          end
        end
        PH_SCHEME_S: begin
          if (lc == CH_LOWER_S && !cur.secure_flag) begin
            nxt.secure_flag = 1'b1;
            cls = CL_SCHEME;
          end else if (ch == CH_COLON) begin
            nxt.phase = PH_SLASH1;
            cls = CL_DELIM;
          end else begin
            bad = 1'b1;
          end
        end
        PH_SLASH1: begin
          if (ch == CH_SLASH) begin
            nxt.phase = PH_SLASH2;
            cls = CL_DELIM;
          end else begin
            bad = 1'b1;
          end
        end
        PH_SLASH2: begin
          if (ch == CH_SLASH) begin
            nxt.phase = PH_HOST;
            cls = CL_DELIM;
          end else begin
            bad = 1'b1;
          end
        end
        PH_HOST: begin
          if (!cur.host_nonempty && ch == CH_LBRACK) begin
            nxt.phase = PH_V6;
            cls = CL_DELIM;
          end else if (!cur.host_nonempty && ch inside {CH_COLON, CH_SLASH, CH_QMARK}) begin
            bad = 1'b1;   // empty host
          end else if (ch == CH_COLON) begin
            nxt.phase = PH_PORT;
            cls = CL_DELIM;
          end else if (ch == CH_SLASH) begin
            nxt.phase = PH_PATH;
            nxt.path_seen = 1'b1;
            cls = CL_PATH;
          end else if (ch == CH_QMARK) begin
            nxt.phase = PH_QUERY;
            cls = CL_DELIM;
          end else begin
            nxt.host_nonempty = 1'b1;
            cls = CL_HOST;
          end
        end
        PH_V6: begin
          if (ch == CH_RBRACK) begin
            nxt.phase = PH_AFTER_V6;
            cls = CL_DELIM;
          end else begin
            cls = CL_HOST;
          end
        end
        PH_AFTER_V6, PH_PORT: begin
          if (cur.phase == PH_PORT && ch inside {[CH_ZERO:CH_NINE]}) begin
            nxt.port_accum = (acc_x10 > {4'd0, PORT_SAT}) ? PORT_SAT : acc_x10[16:0];
            nxt.port_digit_seen = 1'b1;
            cls = CL_PORT;
          end else if (cur.phase == PH_PORT && !port_in_range(cur)) begin
            bad = 1'b1;
          end else if (cur.phase == PH_AFTER_V6 && ch == CH_COLON) begin
            nxt.phase = PH_PORT;
            cls = CL_DELIM;
          end else if (ch == CH_SLASH) begin
            nxt.phase = PH_PATH;
            nxt.path_seen = 1'b1;
            cls = CL_PATH;
          end else if (ch == CH_QMARK) begin
            nxt.phase = PH_QUERY;
            cls = CL_DELIM;
          end else begin
            nxt.phase = PH_IGNORED;  // trailing junk
            cls = CL_IGNORED;
          end
        end
        PH_PATH: begin
          if (ch == CH_QMARK) begin
            nxt.phase = PH_QUERY;
            cls = CL_DELIM;
          end else begin
            cls = CL_PATH;
          end
        end
        PH_QUERY: begin
          nxt.query_seen = 1'b1;
          cls = CL_QUERY;
        end
        PH_IGNORED: begin
          cls = CL_IGNORED;
        end
        default: begin
          bad = 1'b1;
        end
      endcase
      if (bad) begin
        nxt.failed = 1'b1;
        cls = CL_ERROR;
      end
    end
  end

endmodule

### rtl/core/hus_finish.sv
// ----------------------------------------------------------------------------
// hus_finish
// End-of-URL check and report; on the last byte returns the parser to its idle state.
// ----------------------------------------------------------------------------
module hus_finish (
  input  hus_pkg::parse_state_t st,
  input  logic                  last_byte,
  output hus_pkg::url_report_t  rep,
  output hus_pkg::parse_state_t st_next
);
  import hus_pkg::*;

  logic ends_well;

  always_comb begin
    ends_well = 1'b0;
    if (!st.failed) begin
      case (st.phase)
        PH_HOST:     ends_well = st.host_nonempty;
        PH_AFTER_V6: ends_well = 1'b1;
        PH_PORT:     ends_well = port_in_range(st);
        PH_PATH:     ends_well = 1'b1;
        PH_QUERY:    ends_well = 1'b1;
        PH_IGNORED:  ends_well = 1'b1;
        default:     ends_well = 1'b0;
      endcase
    end
  end

  always_comb begin
    rep     = '0;
    st_next = st;
    if (last_byte) begin
      st_next = STATE_RESET;
      if (ends_well) begin
        rep.ok          = 1'b1;
        rep.is_secure   = st.secure_flag;
        rep.port_number = st.port_digit_seen ? st.port_accum[15:0]
                        : (st.secure_flag ? PORT_HTTPS : PORT_HTTP);
        rep.path_given  = st.path_seen;
        rep.query_given = st.query_seen;
      end
    end
  end

endmodule

### rtl/core/http_url_splitter_unit.sv
// ----------------------------------------------------------------------------
// http_url_splitter_unit
// Streaming URL splitter: labels each byte and reports on the last one.
// ----------------------------------------------------------------------------
// One request per URL byte, one result per request, one byte per cycle
// sustained: the parser state and the byte label are updated in a
// single pass and captured in the result register.
// A new byte is taken whenever the result register is empty or its
// contents are taken in the same cycle, so throughput only drops while
// the downstream side holds ready low. After a byte marked last the
// parser returns to its idle state and the next byte starts a new URL.
module http_url_splitter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  byte_class,
  output logic        done_res,
  output logic        ok,
  output logic        is_secure,
  output logic [15:0] port_number,
  output logic        path_given,
  output logic        query_given
);
  import hus_pkg::*;

  parse_state_t state;
  parse_state_t stepped;
  parse_state_t state_next;
  byte_class_t  cls;
  url_report_t  rep;
  logic         in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  hus_step u_step (
    .cur (state),
    .ch  (ch),
    .nxt (stepped),
    .cls (cls)
  );

  hus_finish u_finish (
    .st        (stepped),
    .last_byte (last_byte),
    .rep       (rep),
    .st_next   (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= STATE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_class  <= cls;
      done_res    <= last_byte;
      ok          <= rep.ok;
      is_secure   <= rep.is_secure;
      port_number <= rep.port_number;
      path_given  <= rep.path_given;
      query_given <= rep.query_given;
    end
  end

  // parser is back to idle after the last byte of a URL
  a_restart: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_byte |=> state.phase == PH_SCHEME && !state.failed
                             && !state.port_digit_seen && state.scheme_index == 3'd0)
    else $error("parser not idle after last byte");

  a_ok_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && ok |-> done_res)
    else $error("ok reported on a byte that is not last");

  a_error_not_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_class == CL_ERROR |-> !ok)
    else $error("failed URL reported as parsed");

  a_fields_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> !is_secure && port_number == 16'd0 && !path_given && !query_given)
    else $error("report fields set without ok");

  a_ok_port: assert property (@(posedge clk) disable iff (rst)
    out_valid && ok |-> port_number != 16'd0)
    else $error("zero port on a parsed URL");

endmodule
